// ----- rtl/vdp_pkg.sv -----
// ----------------------------------------------------------------------------
// vdp_pkg
// Shared types and constants for the vector display processor.
// ----------------------------------------------------------------------------
`default_nettype none

package vdp_pkg;

    localparam int BEAM_W = 11;
    localparam int PC_W   = 14;

    localparam logic [1:0] MODE_EXEC  = 2'd0;
    localparam logic [1:0] MODE_START = 2'd1;
    localparam logic [1:0] MODE_STOP  = 2'd2;

    localparam logic [BEAM_W-1:0] BEAM_ALIGN_MASK = 11'h7e0;

    // one result item
    typedef struct packed {
        logic              kind;
        logic [BEAM_W-1:0] from_x;
        logic [BEAM_W-1:0] from_y;
        logic [BEAM_W-1:0] to_x;
        logic [BEAM_W-1:0] to_y;
        logic [PC_W-1:0]   next_pc;
        logic              running;
        logic              deim_active;
        logic              illegal;
        logic [1:0]        cycles;
        logic              last;
    } result_t;

    // scale factor for a scale index
    function automatic logic [2:0] scale_of(input logic [1:0] idx);
        logic [2:0] s;
        begin
            unique case (idx)
                2'd0:    s = 3'd1;
                2'd1:    s = 3'd2;
                2'd2:    s = 3'd4;
                default: s = 3'd6;
            endcase
            return s;
        end
    endfunction

endpackage

`default_nettype wire

// ----- rtl/vdp_byte_unit.sv -----
// ----------------------------------------------------------------------------
// vdp_byte_unit
// Executes one increment-mode byte command on the beam position.
// ----------------------------------------------------------------------------
`default_nettype none

module vdp_byte_unit
    import vdp_pkg::*;
(
    input  wire logic [7:0]        cmd,
    input  wire logic [1:0]        scale_idx,
    input  wire logic [BEAM_W-1:0] x_in,
    input  wire logic [BEAM_W-1:0] y_in,
    output logic [BEAM_W-1:0]      x_out,
    output logic [BEAM_W-1:0]      y_out,
    output logic                   draw,
    output logic                   exit_inc,
    output logic                   do_ret
);

    logic [2:0]        sc;
    logic [BEAM_W-1:0] dx;
    logic [BEAM_W-1:0] dy;
    logic [BEAM_W-1:0] step16;
    logic [BEAM_W-1:0] xt;
    logic [BEAM_W-1:0] yt;

    // decode move or control byte
    always_comb
    begin
        sc     = scale_of(scale_idx);
        dx     = BEAM_W'(cmd[4:3]) * BEAM_W'(sc);
        dy     = BEAM_W'(cmd[1:0]) * BEAM_W'(sc);
        step16 = BEAM_W'({sc, 4'b0000});
        x_out    = x_in;
        y_out    = y_in;
        draw     = 1'b0;
        exit_inc = 1'b0;
        do_ret   = 1'b0;
        xt = x_in;
        yt = y_in;
        if (cmd[7])
        begin
            x_out = cmd[5] ? x_in - dx : x_in + dx;
            y_out = cmd[2] ? y_in - dy : y_in + dy;
            draw  = cmd[6];
        end
        else
        begin
            exit_inc = cmd[6];
            do_ret   = cmd[5];
            if (cmd[4]) xt = xt + step16;
            if (cmd[3]) xt = xt & BEAM_ALIGN_MASK;
            if (cmd[1]) yt = yt + step16;
            if (cmd[0]) yt = yt & BEAM_ALIGN_MASK;
            x_out = xt;
            y_out = yt;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/vector_display_processor.sv -----
// Output: results of an accepted request are registered in the output queue;
// up to three items (two segments and a status) per request.
// Throughput: one request per cycle when each yields one result and out_ready
// is high; a request with more results holds off new ones until its last item is taken.
// Reset: asynchronous, active low; beam, pc, stack depth, flags cleared,
// scale index one. Stack entries are undefined until pushed.
// ----------------------------------------------------------------------------
// vector_display_processor
// Display-list processor: executes at most one instruction word per request.
// ----------------------------------------------------------------------------
`default_nettype none

module vector_display_processor
    import vdp_pkg::*;
#(
    parameter int ADDR_BITS   = 14,
    parameter int STACK_DEPTH = 8
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              cfg_valid,
    output logic                   cfg_ready,
    input  wire logic [PC_W-1:0]   cfg_data,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire logic [1:0]        mode,
    input  wire logic [15:0]       instr_word,
    input  wire logic [15:0]       vector_word_a,
    input  wire logic [15:0]       vector_word_b,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output logic                   kind,
    output logic [BEAM_W-1:0]      from_x,
    output logic [BEAM_W-1:0]      from_y,
    output logic [BEAM_W-1:0]      to_x,
    output logic [BEAM_W-1:0]      to_y,
    output logic [PC_W-1:0]        next_pc,
    output logic                   running,
    output logic                   deim_active,
    output logic                   illegal,
    output logic [1:0]             cycles,
    output logic                   last
);

    localparam int SP_W  = $clog2(STACK_DEPTH + 1);
    localparam int IDX_W = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

    // architectural state
    logic [PC_W-1:0]      start_pc_reg;
    logic [ADDR_BITS-1:0] pc_reg, pc_next;
    logic [ADDR_BITS-1:0] stack_reg [STACK_DEPTH];
    logic [SP_W-1:0]      sp_reg, sp_next;
    logic [BEAM_W-1:0]    bx_reg, bx_next, by_reg, by_next;
    logic [1:0]           scale_reg, scale_next;
    logic                 blk_reg, blk_next;
    logic                 inc_reg, inc_next;
    logic                 run_reg, run_next;
    logic                 push;

    // output queue: up to three items
    result_t              q_reg [3];
    logic [1:0]           cnt_reg;
    result_t              res [3];
    logic [1:0]           nres;

    assign cfg_ready = 1'b1;
    assign in_ready  = (cnt_reg == 2'd0) || (cnt_reg == 2'd1 && out_ready);
    assign out_valid = (cnt_reg != 2'd0);

    // byte units
    logic [7:0]        b0_cmd, b1_cmd;
    logic [BEAM_W-1:0] b0_xi, b0_yi, b0_xo, b0_yo, b1_xo, b1_yo;
    logic              b0_draw, b0_exit, b0_ret, b1_draw, b1_exit, b1_ret;
    logic [BEAM_W-1:0] bx1, by1;

    vdp_byte_unit u_byte0 (
        .cmd(b0_cmd), .scale_idx(scale_reg), .x_in(b0_xi), .y_in(b0_yi),
        .x_out(b0_xo), .y_out(b0_yo), .draw(b0_draw), .exit_inc(b0_exit),
        .do_ret(b0_ret)
    );

    vdp_byte_unit u_byte1 (
        .cmd(b1_cmd), .scale_idx(scale_reg), .x_in(bx1), .y_in(by1),
        .x_out(b1_xo), .y_out(b1_yo), .draw(b1_draw), .exit_inc(b1_exit),
        .do_ret(b1_ret)
    );

    always_comb
    begin
        b0_cmd = inc_reg ? instr_word[15:8] : instr_word[7:0];
        b1_cmd = instr_word[7:0];
        b0_xi  = bx_reg;
        b0_yi  = by_reg;
    end

    // execute one request
    always_comb
    begin
        logic              bad;
        logic [1:0]        cyc;
        logic [11:0]       addr;
        logic [11:0]       mm, nn, ddx, ddy;
        logic [ADDR_BITS-1:0] pc1, jmp;
        logic [SP_W-1:0]   sp_t;
        logic [ADDR_BITS-1:0] pc_t;
        logic              seg0, seg1;
        logic [BEAM_W-1:0] s0fx, s0fy, s0tx, s0ty, s1fx, s1fy;
        result_t           st, sg0, sg1;

        pc_next = pc_reg; sp_next = sp_reg; bx_next = bx_reg; by_next = by_reg;
        scale_next = scale_reg; blk_next = blk_reg; inc_next = inc_reg;
        run_next = run_reg; push = 1'b0;
        bad = 1'b0; cyc = 2'd0; seg0 = 1'b0; seg1 = 1'b0;
        s0fx = bx_reg; s0fy = by_reg; s0tx = bx_reg; s0ty = by_reg;
        s1fx = bx_reg; s1fy = by_reg;
        bx1 = bx_reg; by1 = by_reg;
        addr = instr_word[11:0];
        mm = vector_word_a[11:0];
        nn = vector_word_b[11:0];
        ddx = vector_word_b[12] ? nn : mm;
        ddy = vector_word_b[12] ? mm : nn;
        pc1 = pc_reg + 1'b1;
        jmp = ADDR_BITS'({4'b0, addr} + {4'b0, blk_reg, 12'b0});
        sp_t = sp_reg;
        pc_t = pc1;

        if (mode == MODE_START)
        begin
            pc_next  = ADDR_BITS'(start_pc_reg);
            run_next = 1'b1;
        end
        else if (mode == MODE_STOP)
        begin
            run_next = 1'b0;
        end
        else if (mode == MODE_EXEC && run_reg)
        begin
            pc_next = pc1;
            cyc = 2'd1;
            if (inc_reg)
            begin
                // high byte then low byte
                bx1 = b0_xo; by1 = b0_yo;
                seg0 = b0_draw; s0tx = b0_xo; s0ty = b0_yo;
                if (b0_ret)
                begin
                    if (sp_t == '0 || sp_t > SP_W'(STACK_DEPTH)) bad = 1'b1;
                    else
                    begin
                        sp_t = sp_t - 1'b1;
                        pc_t = stack_reg[sp_t[IDX_W-1:0]];
                    end
                end
                bx_next = b0_xo; by_next = b0_yo;
                if (b0_exit) inc_next = 1'b0;
                else
                begin
                    seg1 = b1_draw; s1fx = b0_xo; s1fy = b0_yo;
                    bx_next = b1_xo; by_next = b1_yo;
                    if (b1_exit) inc_next = 1'b0;
                    if (b1_ret)
                    begin
                        if (sp_t == '0 || sp_t > SP_W'(STACK_DEPTH)) bad = 1'b1;
                        else
                        begin
                            sp_t = sp_t - 1'b1;
                            pc_t = stack_reg[sp_t[IDX_W-1:0]];
                        end
                    end
                end
                sp_next = sp_t; pc_next = pc_t;
            end
            else
            begin
                unique case (instr_word[15:12])
                    4'd0:
                    begin
                        // adding 04000 to an 11-bit beam leaves it where it is
                        priority if (instr_word == 16'o000000) run_next = 1'b0;
                        else if (instr_word == 16'o004000 ||
                                 instr_word == 16'o006000 ||
                                 instr_word == 16'o004400 ||
                                 instr_word == 16'o005000) cyc = 2'd1;
                        else if (instr_word[15:2] == 14'o01001)
                            scale_next = instr_word[1:0];
                        else if (instr_word[15:1] == 15'o02004)
                            blk_next = instr_word[0];
                        else if (instr_word == 16'o004040)
                        begin
                            if (sp_reg == '0 || sp_reg > SP_W'(STACK_DEPTH)) bad = 1'b1;
                            else
                            begin
                                sp_next = sp_reg - 1'b1;
                                pc_next = stack_reg[sp_next[IDX_W-1:0]];
                            end
                        end
                        else if (instr_word == 16'o004100) by_next = by_reg - 11'o2000;
                        else if (instr_word == 16'o004200) bx_next = bx_reg - 11'o2000;
                        else bad = 1'b1;
                    end
                    4'd1: bx_next = {1'b0, addr[9:0]};
                    4'd2: by_next = {1'b0, addr[9:0]};
                    4'd3:
                    begin
                        inc_next = 1'b1;
                        bx_next = b0_xo; by_next = b0_yo;
                        seg0 = b0_draw; s0tx = b0_xo; s0ty = b0_yo;
                        if (b0_exit) inc_next = 1'b0;
                        if (b0_ret)
                        begin
                            if (sp_reg == '0 || sp_reg > SP_W'(STACK_DEPTH)) bad = 1'b1;
                            else
                            begin
                                sp_next = sp_reg - 1'b1;
                                pc_next = stack_reg[sp_next[IDX_W-1:0]];
                            end
                        end
                    end
                    4'd4:
                    begin
                        cyc = 2'd3;
                        pc_next = pc_reg + ADDR_BITS'(3);
                        bx_next = vector_word_b[14] ? bx_reg - ddx[10:0] : bx_reg + ddx[10:0];
                        by_next = vector_word_b[13] ? by_reg - ddy[10:0] : by_reg + ddy[10:0];
                        seg0 = 1'b1; s0tx = bx_next; s0ty = by_next;
                    end
                    4'd5:
                    begin
                        if (sp_reg >= SP_W'(STACK_DEPTH)) bad = 1'b1;
                        else
                        begin
                            push = 1'b1;
                            sp_next = sp_reg + 1'b1;
                            pc_next = jmp;
                        end
                    end
                    4'd6: pc_next = jmp;
                    default: bad = 1'b1;
                endcase
            end
            if (bad) cyc = 2'd0;
        end

        // segments report the beam after their own move
        if (seg1) s0tx = b0_xo;
        sg0 = '0; sg0.from_x = s0fx; sg0.from_y = s0fy; sg0.to_x = s0tx; sg0.to_y = s0ty;
        sg1 = '0; sg1.from_x = s1fx; sg1.from_y = s1fy; sg1.to_x = b1_xo; sg1.to_y = b1_yo;
        st = '0;
        st.kind = 1'b1; st.to_x = bx_next; st.to_y = by_next;
        st.next_pc = PC_W'(pc_next); st.running = run_next;
        st.deim_active = inc_next; st.illegal = bad; st.cycles = cyc; st.last = 1'b1;

        res[0] = st; res[1] = st; res[2] = st; nres = 2'd1;
        priority if (seg0 && seg1)
        begin
            res[0] = sg0; res[1] = sg1; nres = 2'd3;
        end
        else if (seg0)
        begin
            res[0] = sg0; nres = 2'd2;
        end
        else if (seg1)
        begin
            res[0] = sg1; nres = 2'd2;
        end
        else
        begin
            nres = 2'd1;
        end
        if (seg0 && !seg1) res[1] = st;
        if (!seg0 && seg1) res[1] = st;
    end

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_pc_reg <= '0; pc_reg <= '0; sp_reg <= '0;
            bx_reg <= '0; by_reg <= '0; scale_reg <= 2'd1;
            blk_reg <= 1'b0; inc_reg <= 1'b0; run_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready) start_pc_reg <= cfg_data;
            if (in_valid && in_ready)
            begin
                pc_reg <= pc_next; sp_reg <= sp_next; bx_reg <= bx_next;
                by_reg <= by_next; scale_reg <= scale_next; blk_reg <= blk_next;
                inc_reg <= inc_next; run_reg <= run_next;
            end
        end
    end

    // return stack entries
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready && push)
            stack_reg[sp_reg[IDX_W-1:0]] <= pc_reg + 1'b1;
    end

    // output queue: load a request's items or shift after each take
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= 2'd0;
        else if (in_valid && in_ready)
            cnt_reg <= nres;
        else if (out_valid && out_ready)
            cnt_reg <= cnt_reg - 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            q_reg[0] <= res[0]; q_reg[1] <= res[1]; q_reg[2] <= res[2];
        end
        else if (out_valid && out_ready)
        begin
            q_reg[0] <= q_reg[1]; q_reg[1] <= q_reg[2];
        end
    end

    assign kind = q_reg[0].kind;
    assign from_x = q_reg[0].from_x;
    assign from_y = q_reg[0].from_y;
    assign to_x = q_reg[0].to_x;
    assign to_y = q_reg[0].to_y;
    assign next_pc = q_reg[0].next_pc;
    assign running = q_reg[0].running;
    assign deim_active = q_reg[0].deim_active;
    assign illegal = q_reg[0].illegal;
    assign cycles = q_reg[0].cycles;
    assign last = q_reg[0].last;

endmodule

`default_nettype wire

// ----- dv/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the vector display processor: a queue-fed driver
// offers start, stop, execute and unused-mode requests, a predictor models the
// display state, and a monitor compares every result item with the oldest
// expected one. Runs random phases of idling and stalls plus one long output hold-off.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;
    import vdp_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int STK = 8;
    localparam int WATCHDOG = 20000;

    typedef struct packed {
        logic [1:0]  mode;
        logic [15:0] w;
        logic [15:0] wa;
        logic [15:0] wb;
    } req_t;

    logic clk, rst_n;
    logic cfg_valid, cfg_ready;
    logic [PC_W-1:0] cfg_data;
    logic in_valid, in_ready;
    logic [1:0] mode;
    logic [15:0] instr_word, vector_word_a, vector_word_b;
    logic out_valid, out_ready;
    result_t act;

    vector_display_processor dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_ready(in_ready), .mode(mode),
        .instr_word(instr_word), .vector_word_a(vector_word_a),
        .vector_word_b(vector_word_b),
        .out_valid(out_valid), .out_ready(out_ready),
        .kind(act.kind), .from_x(act.from_x), .from_y(act.from_y),
        .to_x(act.to_x), .to_y(act.to_y), .next_pc(act.next_pc),
        .running(act.running), .deim_active(act.deim_active),
        .illegal(act.illegal), .cycles(act.cycles), .last(act.last)
    );

    // display state copy
    logic [13:0] m_start, m_pc;
    logic [13:0] m_stack [STK];
    int          m_depth;
    logic [10:0] m_bx, m_by;
    logic [1:0]  m_scale;
    logic        m_block, m_incr, m_run, m_bad;

    req_t    pending_reqs[$];
    result_t expected_items[$];
    int      send_idle_pct, stall_pct, errors, quiet_cycles;
    bit      hold_off;

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    function automatic logic [10:0] scale_amt();
        case (m_scale)
            2'd0:    return 11'd1;
            2'd1:    return 11'd2;
            2'd2:    return 11'd4;
            default: return 11'd6;
        endcase
    endfunction

    function automatic void push_segment(logic [10:0] fx, logic [10:0] fy);
        result_t r;
        r = '0;
        r.from_x = fx;
        r.from_y = fy;
        r.to_x = m_bx;
        r.to_y = m_by;
        expected_items.push_back(r);
    endfunction

    function automatic void pop_return();
        if (m_depth == 0)
            m_bad = 1'b1;
        else
        begin
            m_depth--;
            m_pc = m_stack[m_depth];
        end
    endfunction

    // one increment-mode byte command
    function automatic void run_byte(logic [7:0] b);
        logic [10:0] sc, fx, fy, dx, dy;
        sc = scale_amt();
        if (b[7])
        begin
            fx = m_bx;
            fy = m_by;
            dx = 11'(b[4:3]) * sc;
            dy = 11'(b[1:0]) * sc;
            m_bx = b[5] ? m_bx - dx : m_bx + dx;
            m_by = b[2] ? m_by - dy : m_by + dy;
            if (b[6])
                push_segment(fx, fy);
        end
        else
        begin
            if (b[6]) m_incr = 1'b0;
            if (b[5]) pop_return();
            if (b[4]) m_bx = m_bx + 11'(16 * sc);
            if (b[3]) m_bx = m_bx & BEAM_ALIGN_MASK;
            if (b[1]) m_by = m_by + 11'(16 * sc);
            if (b[0]) m_by = m_by & BEAM_ALIGN_MASK;
        end
    endfunction

    function automatic logic [1:0] run_word(req_t q);
        logic [11:0] addr;
        logic [11:0] mj, mn, ddx, ddy;
        logic [10:0] fx, fy;
        addr = q.w[11:0];
        m_pc = m_pc + 14'd1;
        if (m_incr)
        begin
            run_byte(q.w[15:8]);
            if (m_incr)
                run_byte(q.w[7:0]);
            return 2'd1;
        end
        case (q.w[15:12])
            4'd0:
                case (q.w)
                    16'o000000: m_run = 1'b0;
                    16'o004000, 16'o006000: ;
                    16'o004004, 16'o004005, 16'o004006, 16'o004007:
                        m_scale = q.w[1:0];
                    16'o004010, 16'o004011: m_block = q.w[0];
                    16'o004040: pop_return();
                    16'o004100: m_by = m_by - 11'o2000;
                    16'o004200: m_bx = m_bx - 11'o2000;
                    16'o004400, 16'o005000: ;  // adds of 04000 wrap away
                    default:
                    begin
                        m_bad = 1'b1;
                        return 2'd0;
                    end
                endcase
            4'd1: m_bx = 11'(addr & 12'o1777);
            4'd2: m_by = 11'(addr & 12'o1777);
            4'd3:
            begin
                m_incr = 1'b1;
                run_byte(addr[7:0]);
            end
            4'd4:
            begin
                fx = m_bx;
                fy = m_by;
                mj = q.wa[11:0];
                mn = q.wb[11:0];
                ddx = q.wb[12] ? mn : mj;
                ddy = q.wb[12] ? mj : mn;
                m_pc = m_pc + 14'd2;
                m_bx = q.wb[14] ? m_bx - 11'(ddx) : m_bx + 11'(ddx);
                m_by = q.wb[13] ? m_by - 11'(ddy) : m_by + 11'(ddy);
                push_segment(fx, fy);
                return 2'd3;
            end
            4'd5:
            begin
                if (m_depth >= STK)
                begin
                    m_bad = 1'b1;
                    return 2'd0;
                end
                m_stack[m_depth] = m_pc;
                m_depth++;
                m_pc = 14'(addr) + {m_block, 12'd0};
            end
            4'd6: m_pc = 14'(addr) + {m_block, 12'd0};
            default:
            begin
                m_bad = 1'b1;
                return 2'd0;
            end
        endcase
        return 2'd1;
    endfunction

    function automatic void predict_display(req_t q);
        result_t r;
        logic [1:0] cyc;
        cyc = 2'd0;
        m_bad = 1'b0;
        if (q.mode == MODE_START)
        begin
            m_pc = m_start;
            m_run = 1'b1;
        end
        else if (q.mode == MODE_STOP)
            m_run = 1'b0;
        else if (q.mode == MODE_EXEC && m_run)
            cyc = run_word(q);
        r = '0;
        r.kind = 1'b1;
        r.to_x = m_bx;
        r.to_y = m_by;
        r.next_pc = m_pc;
        r.running = m_run;
        r.deim_active = m_incr;
        r.illegal = m_bad;
        r.cycles = m_bad ? 2'd0 : cyc;
        r.last = 1'b1;
        expected_items.push_back(r);
    endfunction

    function automatic void add_req(logic [1:0] md, logic [15:0] w,
                                    logic [15:0] wa = 16'h0, logic [15:0] wb = 16'h0);
        req_t q;
        q.mode = md;
        q.w = w;
        q.wa = wa;
        q.wb = wb;
        pending_reqs.push_back(q);
    endfunction

    // random instruction word, mostly legal opcodes
    function automatic logic [15:0] rand_word();
        logic [15:0] pz [12] = '{16'o000000, 16'o004000, 16'o004004, 16'o004005,
            16'o004006, 16'o004007, 16'o004010, 16'o004011, 16'o004040,
            16'o004100, 16'o004200, 16'o006000};
        int k;
        k = $urandom_range(0, 99);
        if (k < 12) return pz[$urandom_range(0, 11)];
        if (k < 14) return 16'o004400 + 16'($urandom_range(0, 1)) * 16'o000400;
        if (k < 17) return 16'($urandom);
        if (k < 30) return {4'd3, 12'($urandom)};
        if (k < 45) return {4'd4, 12'($urandom)};
        if (k < 58) return {4'd5, 12'($urandom)};
        if (k < 66) return {4'd6, 12'($urandom)};
        if (k < 72) return {4'($urandom_range(1, 2)), 12'($urandom)};
        return 16'($urandom);  // bytes when in increment mode
    endfunction

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            mode <= MODE_EXEC;
            instr_word <= '0;
            vector_word_a <= '0;
            vector_word_b <= '0;
        end
        else if (!in_valid || in_ready)
        begin
            if (pending_reqs.size() > 0 && $urandom_range(0, 99) >= send_idle_pct)
            begin
                req_t q;
                q = pending_reqs.pop_front();
                in_valid <= 1'b1;
                mode <= q.mode;
                instr_word <= q.w;
                vector_word_a <= q.wa;
                vector_word_b <= q.wb;
                predict_display(q);
            end
            else
                in_valid <= 1'b0;
        end
    end

    // output ready
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else
            out_ready <= !hold_off && $urandom_range(0, 99) >= stall_pct;
    end

    // monitor
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_items.size() == 0)
            begin
                $error("result with no request outstanding");
                errors++;
            end
            else
            begin
                result_t e;
                e = expected_items.pop_front();
                if (act.kind !== e.kind)
                    begin $error("kind exp %0d got %0d", e.kind, act.kind); errors++; end
                if (act.from_x !== e.from_x)
                    begin $error("from_x exp %0d got %0d", e.from_x, act.from_x); errors++; end
                if (act.from_y !== e.from_y)
                    begin $error("from_y exp %0d got %0d", e.from_y, act.from_y); errors++; end
                if (act.to_x !== e.to_x)
                    begin $error("to_x exp %0d got %0d", e.to_x, act.to_x); errors++; end
                if (act.to_y !== e.to_y)
                    begin $error("to_y exp %0d got %0d", e.to_y, act.to_y); errors++; end
                if (act.next_pc !== e.next_pc)
                    begin $error("next_pc exp %0d got %0d", e.next_pc, act.next_pc); errors++; end
                if (act.running !== e.running)
                    begin $error("running exp %0d got %0d", e.running, act.running); errors++; end
                if (act.deim_active !== e.deim_active)
                    begin
                        $error("deim_active exp %0d got %0d", e.deim_active, act.deim_active);
                        errors++;
                    end
                if (act.illegal !== e.illegal)
                    begin $error("illegal exp %0d got %0d", e.illegal, act.illegal); errors++; end
                if (act.cycles !== e.cycles)
                    begin $error("cycles exp %0d got %0d", e.cycles, act.cycles); errors++; end
                if (act.last !== e.last)
                    begin $error("last exp %0d got %0d", e.last, act.last); errors++; end
            end
        end
    end

    // watchdog on accepted traffic
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    task automatic write_start_pc(logic [13:0] v);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data <= v;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        m_start = v;
    endtask

    task automatic drain();
        while (pending_reqs.size() > 0 || expected_items.size() > 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
    endtask

    // random phase: mostly running programs, some stops and junk modes
    task automatic run_phase(int n, int idle, int stall);
        int k;
        send_idle_pct = idle;
        stall_pct = stall;
        add_req(MODE_START, 16'($urandom));
        for (int i = 0; i < n; i++)
        begin
            k = $urandom_range(0, 99);
            if (k < 3)
                add_req(MODE_STOP, 16'($urandom));
            else if (k < 7)
                add_req(MODE_START, 16'($urandom));
            else if (k < 9)
                add_req(2'd3, 16'($urandom));
            else
                add_req(MODE_EXEC, rand_word(), 16'($urandom), 16'($urandom));
        end
        drain();
    endtask

    initial
    begin
        errors = 0;
        quiet_cycles = 0;
        hold_off = 1'b0;
        send_idle_pct = 0;
        stall_pct = 0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        rst_n = 1'b0;
        m_start = '0; m_pc = '0; m_depth = 0; m_bx = '0; m_by = '0;
        m_scale = 2'd1; m_block = 1'b0; m_incr = 1'b0; m_run = 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // directed: extremes, every opcode but the jump, stack edges
        write_start_pc(14'h3fff);
        add_req(MODE_EXEC, 16'o010000);          // execute while stopped
        add_req(2'd3, 16'hffff);
        add_req(MODE_START, 16'h0);
        add_req(MODE_EXEC, 16'o004040);          // return underflow
        add_req(MODE_EXEC, 16'o011777);
        add_req(MODE_EXEC, 16'o027777);
        add_req(MODE_EXEC, 16'h4000, 16'hffff, 16'h7fff);
        add_req(MODE_EXEC, 16'h4000, 16'h0fff, 16'h1abc);
        add_req(MODE_EXEC, 16'o004007);
        add_req(MODE_EXEC, 16'o004011);
        add_req(MODE_EXEC, 16'o004100);
        add_req(MODE_EXEC, 16'o004200);
        add_req(MODE_EXEC, 16'o004400);
        add_req(MODE_EXEC, 16'o005000);
        for (int i = 0; i < 9; i++)
            add_req(MODE_EXEC, 16'h5fff);        // last call overflows
        add_req(MODE_EXEC, 16'h3000 | 16'hd7);   // increment mode, draw byte
        add_req(MODE_EXEC, 16'hfb3b);            // draw, then return/align byte
        add_req(MODE_EXEC, 16'h7123);            // control byte: return and exit increment mode
        add_req(MODE_EXEC, 16'o003000);          // unknown page-zero word
        add_req(MODE_EXEC, 16'o006000);
        add_req(MODE_EXEC, 16'o000000);          // halt
        add_req(MODE_STOP, 16'hffff, 16'hffff, 16'hffff);
        drain();

        write_start_pc(14'h0);
        run_phase(30, 0, 0);
        write_start_pc(14'($urandom));
        run_phase(30, 45, 0);
        write_start_pc(14'h1000);
        run_phase(30, 0, 45);
        write_start_pc(14'($urandom));

        // hold the output off while requests keep coming
        send_idle_pct = 0;
        for (int i = 0; i < 20; i++)
            add_req(MODE_EXEC, {4'd4, 12'($urandom)}, 16'($urandom), 16'($urandom));
        hold_off = 1'b1;
        repeat (60) @(posedge clk);
        hold_off = 1'b0;
        drain();
        run_phase(30, 25, 25);

        if (errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

`default_nettype wire
